[sv/mted_pkg.sv]
package mted_pkg;

    // History store geometry. The delay fields are 12 bits wide, so a
    // store of 4096 entries takes every delay modulo its depth for free.
    localparam int DEPTH      = 4096;
    localparam int IDX_W      = 12;
    localparam int DELAY_W    = 12;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 15;
    localparam int TAP_REGS   = 4;
    localparam int TAP_IDX_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_GAIN = 3'd0,
        REG_TAP0       = 3'd1,
        REG_TAP1       = 3'd2,
        REG_TAP2       = 3'd3,
        REG_TAP3       = 3'd4
    } mted_reg_t;

    localparam logic [GAIN_W-1:0] INPUT_GAIN_RESET = 16'd16384;

    typedef logic [CFG_DATA_W-1:0] tap_setting_t;

    localparam tap_setting_t TAP_RESET [TAP_REGS] = '{
        28'd33555456, 28'd16778752, 28'd8391168, 28'd8391680
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 clear_wr;
        logic                 accept;
        logic                 rd_en;
        logic [TAP_IDX_W-1:0] rd_tap;
        logic                 load_out;
        logic                 advance_w;
    } mted_cmd_t;

    typedef struct packed {
        logic clear_last;
    } mted_status_t;

endpackage

[sv/mted_in_if.sv]
interface mted_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink (input valid, input in_sample, output ready);
endinterface

[sv/mted_out_if.sv]
interface mted_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink (input valid, input out_sample, output ready);
endinterface

[sv/mted_cfg_if.sv]
interface mted_cfg_if
    import mted_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/mted_ram.sv]
module mted_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[sv/mted_ctrl.sv]
module mted_ctrl
    import mted_pkg::*;
#(
    parameter int NUM_TAPS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output mted_cmd_t    cmd,
    input  mted_status_t status
);

    localparam int USED_TAPS = (NUM_TAPS < TAP_REGS) ? NUM_TAPS : TAP_REGS;
    localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(USED_TAPS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [TAP_IDX_W-1:0] tap_reg, tap_next;
    logic                 drain_reg, drain_next;
    logic                 out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.rd_tap     = tap_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    tap_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
                if (tap_reg == LAST_TAP)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // The drain covers the tap multiply and then the last add.
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.advance_w  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            tap_reg       <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/mted_dp.sv]
module mted_dp
    import mted_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mted_cmd_t                     cmd,
    output mted_status_t                  status,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    input  logic                          cfg_valid,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SH_W   = ACC_W - GAIN_FRAC;

    // Configuration registers.
    logic signed [GAIN_W-1:0] input_gain_reg;
    tap_setting_t             tap_setting_reg [TAP_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_gain_reg  <= INPUT_GAIN_RESET;
            tap_setting_reg <= TAP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index) inside
                REG_INPUT_GAIN:
                begin
                    input_gain_reg <= cfg_data[GAIN_W-1:0];
                end
                REG_TAP0, REG_TAP1, REG_TAP2, REG_TAP3:
                begin
                    tap_setting_reg[TAP_IDX_W'(cfg_index - 1'b1)] <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Write position and clearing sweep.
    logic [IDX_W-1:0] w_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= IDX_W'(DEPTH - 1);
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.advance_w)
            begin
                w_reg <= w_reg + 1'b1;
            end
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    assign status.clear_last = (clr_addr_reg == {IDX_W{1'b1}});

    // History store port.
    logic [DELAY_W-1:0]     delay_sel;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       ram_addr;
    logic                   ram_we;
    logic                   ram_en;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    assign delay_sel = tap_setting_reg[cmd.rd_tap][DELAY_W-1:0];
    assign rd_addr   = w_reg - delay_sel;
    assign ram_we    = cmd.clear_wr | cmd.accept;
    assign ram_en    = ram_we | cmd.rd_en;
    assign ram_wdata = cmd.clear_wr ? '0 : in_sample;

    always_comb
    begin
        if (cmd.clear_wr)
        begin
            ram_addr = clr_addr_reg;
        end
        else if (cmd.accept)
        begin
            ram_addr = w_reg;
        end
        else
        begin
            ram_addr = rd_addr;
        end
    end

    mted_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_hist (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Multiply stage: the direct path on accept, a tap once its read returns.
    logic                          rd_valid_reg;
    logic [TAP_IDX_W-1:0]          rd_tap_reg;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [GAIN_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]      product_reg;
    logic                          prod_valid_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    assign mul_a = rd_valid_reg ? $signed(ram_rdata) : in_sample;
    assign mul_b = rd_valid_reg ? $signed(tap_setting_reg[rd_tap_reg][CFG_DATA_W-1:DELAY_W])
                                : input_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.rd_en;
            prod_valid_reg <= rd_valid_reg | cmd.accept;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tap_reg  <= cmd.rd_tap;
        product_reg <= mul_a * mul_b;
        if (cmd.accept)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(product_reg);
        end
    end

    // Floor shift by the gain fraction, then saturate.
    logic signed [SH_W-1:0]        shifted;
    logic signed [SAMPLE_BITS-1:0] sat_value;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;

    assign shifted = acc_reg[ACC_W-1:GAIN_FRAC];

    always_comb
    begin
        if (shifted[SH_W-1:SAMPLE_BITS-1] == '0 || shifted[SH_W-1:SAMPLE_BITS-1] == '1)
        begin
            sat_value = shifted[SAMPLE_BITS-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            sat_value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_sample_reg <= sat_value;
        end
    end

    assign out_sample = out_sample_reg;

endmodule

[sv/multitap_echo_delay_core.sv]
// Multitap echo delay line: one item in, one item out.
// Items are taken one at a time: the next input item is accepted only after the current
// result is loaded into the output register. The single-port history RAM takes the
// write and then one tap read per cycle. Reset: the configuration registers return to
// their defaults, and a clearing pass over all 4096 entries zeroes the history store
// before the first input item is accepted; configuration is open at once.
module multitap_echo_delay_core
    import mted_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int NUM_TAPS    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    mted_in_if.sink     in_ch,
    mted_out_if.source  out_ch,
    mted_cfg_if.sink    cfg
);

    // The controller sequences each item: in the accept cycle the sample is
    // written to the history RAM at the write position and multiplied by the
    // input gain; then a read is issued for each tap in turn at the write
    // position minus that tap's delay. Read data, tap multiply and accumulate
    // follow in a pipeline, drained by the drain state before the sum is final.
    // The saturated result then lands in the output register, which lets the
    // next item enter while the current result still waits downstream.
    mted_cmd_t    cmd;
    mted_status_t status;

    mted_ctrl #(
        .NUM_TAPS (NUM_TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Configuration writes are taken in any cycle; the datapath decodes the
    // register index and ignores indexes past the last tap.
    assign cfg.ready = 1'b1;

    mted_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_sample  (in_ch.in_sample),
        .out_sample (out_ch.out_sample),
        .cfg_valid  (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data)
    );

endmodule

[bench/tb_top.sv]
module tb_top
    import mted_pkg::*;
;

    // The block under test runs with four taps and 16-bit samples.
    localparam int SAMPLE_BITS = 16;
    localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_BITS - 1));

    // RESULT_LATENCY covers the wait from a taken item to its result.
    // The quiet period before a register write gives it some margin on top.
    localparam int RESULT_LATENCY = TAP_REGS + 3;
    localparam int QUIET_CYCLES = RESULT_LATENCY + 4;

    // The long receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_CYCLES = 400;

    // The slowest correct run is the clearing pass, then about 500 items
    // with their sender gaps, block work and receiver stalls, plus the
    // hold-off and the register writes. The limit is several times that.
    localparam int LIMIT_CYCLES = 300000;

    // Number of codes the register index field can carry.
    localparam int REG_SPACE = 1 << CFG_IDX_W;

    localparam int RANDOM_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int MAX_REPORTS = 20;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    mted_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    mted_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();
    mted_cfg_if cfg ();

    multitap_echo_delay_core #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .NUM_TAPS   (TAP_REGS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch),
        .cfg   (cfg)
    );

    // ------------------------------------------------------------------
    // Echo predictor. It keeps its own copy of the history store, the
    // write position and the registers, and works out each output sample
    // at the moment its input item is taken by the block.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] history_copy [DEPTH];
    logic [IDX_W-1:0]              write_pos;
    logic signed [GAIN_W-1:0]      direct_gain;
    tap_setting_t                  tap_copy [TAP_REGS];

    // Output samples still owed by the block, oldest first.
    logic signed [SAMPLE_BITS-1:0] echo_expected [$];

    int mismatch_count = 0;
    int unsigned cycle_count = 0;

    function automatic void reset_echo_state();
        int i;
        for (i = 0; i < DEPTH; i++)
            history_copy[i] = '0;
        write_pos = IDX_W'(DEPTH - 1);
        direct_gain = INPUT_GAIN_RESET;
        for (i = 0; i < TAP_REGS; i++)
            tap_copy[i] = TAP_RESET[i];
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (mted_reg_t'(idx))
            REG_INPUT_GAIN: direct_gain = val[GAIN_W-1:0];
            REG_TAP0:       tap_copy[0] = val;
            REG_TAP1:       tap_copy[1] = val;
            REG_TAP2:       tap_copy[2] = val;
            REG_TAP3:       tap_copy[3] = val;
            // Indexes past the last tap register are dropped by the block.
            default:        ;
        endcase
    endfunction

    // The new sample goes into the store first, so a tap with zero delay
    // reads it back in the same step. The read position wraps naturally
    // in 12 bits, which is the store depth. The Q5.30 sum is shifted with
    // an arithmetic shift, which rounds toward negative infinity.
    function automatic logic signed [SAMPLE_BITS-1:0] predict_echo(
        input logic signed [SAMPLE_BITS-1:0] x);
        longint                   acc;
        longint                   y;
        logic signed [GAIN_W-1:0] g;
        logic [IDX_W-1:0]         rd;
        int                       j;
        history_copy[write_pos] = x;
        acc = longint'(x) * longint'(direct_gain);
        for (j = 0; j < TAP_REGS; j++)
        begin
            g = tap_copy[j][CFG_DATA_W-1:DELAY_W];
            rd = write_pos - tap_copy[j][DELAY_W-1:0];
            acc += longint'(g) * longint'(history_copy[rd]);
        end
        y = acc >>> GAIN_FRAC;
        if (y > SAMPLE_MAX)
            y = SAMPLE_MAX;
        if (y < SAMPLE_MIN)
            y = SAMPLE_MIN;
        write_pos = write_pos + 1'b1;
        return y[SAMPLE_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("ERROR at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the
    // inputs driven at the falling edge are stable and the block's
    // outputs still hold their pre-edge values. Register writes,
    // accepted items and results are handled in one process so the
    // queue of expected samples has a single owner.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] want_sample;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                apply_register(cfg.index, cfg.data);
            if (in_ch.valid && in_ch.ready)
                echo_expected.push_back(predict_echo(in_ch.in_sample));
            if (out_ch.valid && out_ch.ready)
            begin
                if (echo_expected.size() == 0)
                begin
                    report_mismatch($sformatf("out_sample %0d arrived with no item pending",
                                              out_ch.out_sample));
                end
                else
                begin
                    want_sample = echo_expected.pop_front();
                    if (out_ch.out_sample !== want_sample)
                        report_mismatch($sformatf("out_sample got %0d, want %0d",
                                                  out_ch.out_sample, want_sample));
                end
            end
        end
    end

    // Watchdog: a run that never drains ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("multitap_echo_delay_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Ready follows a pattern of its own: open runs of random
    // length, now and then a long free stretch, and stalls in between,
    // so that stalls land at every point of the block's work.
    // A hold-off request overrides the pattern for a long stretch.
    // ------------------------------------------------------------------
    event        hold_go;
    bit          holding;
    int unsigned rx_run = 0;
    bit          rx_open = 1'b0;

    always @(negedge clk)
    begin
        if (holding)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_run == 0)
            begin
                rx_open = !rx_open;
                if (rx_open)
                    rx_run = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
                else
                    rx_run = $urandom_range(1, 10);
            end
            out_ch.ready <= rx_open;
            rx_run--;
        end
    end

    // The hold-off is counted here, at the rising edge, so the receiver
    // sees a settled flag at every falling edge.
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_go);
            @(posedge clk);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Items go out in bursts of random length with random gaps
    // in between; a gap limit of zero gives a stretch with no idling.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_max = 0;

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
                in_ch.in_sample <= SAMPLE_BITS'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.in_sample <= s;
        do @(posedge clk); while (!in_ch.ready);
        burst_left--;
    endtask

    // Drops valid, waits for every owed result, then lets the block go
    // quiet so a register write cannot land on work in flight.
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (echo_expected.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic tap_setting_t tap_word(input logic [DELAY_W-1:0] delay,
                                              input logic signed [GAIN_W-1:0] gain);
        return {gain, delay};
    endfunction

    // Samples: one in five is a full-scale or near-zero value.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic signed [SAMPLE_BITS-1:0] s;
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       s = SAMPLE_BITS'(SAMPLE_MAX);
                1:       s = SAMPLE_BITS'(SAMPLE_MIN);
                2:       s = '0;
                default: s = '1;
            endcase
        end
        else
        begin
            s = SAMPLE_BITS'($urandom);
        end
        return s;
    endfunction

    // Gains: extremes in extreme phases and one time in five otherwise, else
    // random values that are often scaled down so that not every output saturates.
    function automatic logic signed [GAIN_W-1:0] pick_gain(input bit extreme);
        logic signed [GAIN_W-1:0] g;
        if (extreme || $urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       g = 16'sh7FFF;
                1:       g = 16'sh8000;
                2:       g = '0;
                default: g = '1;
            endcase
        end
        else
        begin
            g = GAIN_W'($urandom);
            g = g >>> $urandom_range(0, 3);
        end
        return g;
    endfunction

    // Delays: mostly short, so the taps read samples this run has written.
    function automatic logic [DELAY_W-1:0] pick_delay(input bit extreme);
        logic [DELAY_W-1:0] d;
        if (extreme)
        begin
            case ($urandom_range(0, 2))
                0:       d = '0;
                1:       d = '1;
                default: d = 12'd1;
            endcase
        end
        else if ($urandom_range(0, 9) < 7)
        begin
            d = DELAY_W'($urandom_range(0, 63));
        end
        else
        begin
            d = DELAY_W'($urandom);
        end
        return d;
    endfunction

    // The unused upper bits of the gain write carry noise; the block keeps
    // only the low 16 bits.
    task automatic load_random_settings(input bit extreme);
        int j;
        write_reg(REG_INPUT_GAIN, {12'($urandom), pick_gain(extreme)});
        for (j = 0; j < TAP_REGS; j++)
            write_reg(CFG_IDX_W'(int'(REG_TAP0) + j),
                      tap_word(pick_delay(extreme), pick_gain(extreme)));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset settings: the taps look far back into a store that the
    // clearing pass has zeroed. The first items also wait out that pass.
    task automatic test_reset_settings();
        gap_max = 3;
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        wait_idle();
    endtask

    // Full positive gains. The first tap has zero delay and reads the
    // sample written in the same step; the last looks back the whole
    // store. Runs of full-scale samples saturate in both directions.
    task automatic test_positive_saturation();
        write_reg(REG_INPUT_GAIN, 28'(16'sh7FFF));
        write_reg(REG_TAP0, tap_word(12'd0, 16'sh7FFF));
        write_reg(REG_TAP1, tap_word(12'd1, 16'sh7FFF));
        write_reg(REG_TAP2, tap_word(12'd2, 16'sh7FFF));
        write_reg(REG_TAP3, tap_word(12'hFFF, 16'sh7FFF));
        gap_max = 0;
        repeat (3) send_sample(16'sh7FFF);
        repeat (3) send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        wait_idle();
    endtask

    // Most negative gains, and writes to the indexes past the last tap
    // register, which the block must ignore.
    task automatic test_negative_gains_and_unused_index();
        int idx;
        for (idx = int'(REG_TAP3) + 1; idx < REG_SPACE; idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        write_reg(REG_INPUT_GAIN, 28'hFFF8000);
        write_reg(REG_TAP0, tap_word(12'd0, 16'sh8000));
        write_reg(REG_TAP1, tap_word(12'hFFF, 16'sh8000));
        write_reg(REG_TAP2, tap_word(12'd3, 16'sh8000));
        write_reg(REG_TAP3, tap_word(12'd2048, 16'sh8000));
        gap_max = 5;
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        send_sample(16'sh0000);
        wait_idle();
    endtask

    // Random settings phase by phase, with extreme settings every third
    // phase and a sender gap limit picked at random each time. Changing delays
    // between phases also checks that a new delay counts from the
    // current write position.
    task automatic test_random_phases();
        int p;
        int unsigned gap_choices [3] = '{0, 3, 12};
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            load_random_settings(p % 3 == 0);
            gap_max = gap_choices[$urandom_range(0, 2)];
            repeat (ITEMS_PER_PHASE) send_sample(pick_sample());
            wait_idle();
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming,
    // so the block fills up and stops taking input until it is released.
    task automatic test_backpressure();
        load_random_settings(1'b0);
        gap_max = 0;
        -> hold_go;
        repeat (30) send_sample(pick_sample());
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_sample = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        reset_echo_state();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_positive_saturation();
        test_negative_gains_and_unused_index();
        test_random_phases();
        test_backpressure();

        // Every result is in; give the block a little longer to show any
        // stray output before the verdict.
        wait_idle();
        repeat (RESULT_LATENCY * 3) @(posedge clk);
        if (echo_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", echo_expected.size()));

        if (mismatch_count == 0)
        begin
            $display("multitap_echo_delay_core: match");
        end
        else
        begin
            $display("multitap_echo_delay_core: mismatch");
        end
        $finish;
    end

endmodule
